/* hdl/cpu8x_pkg.sv */
// package for the 8-bit cpu execute unit: operation codes, decoded word type
// and flag bit positions; no dependencies
package cpu8x_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = 1;

    localparam logic [5:0] OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3;
    localparam logic [5:0] OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7;
    localparam logic [5:0] OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11;
    localparam logic [5:0] OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15;
    localparam logic [5:0] OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19;
    localparam logic [5:0] OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23;
    localparam logic [5:0] OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_LDA = 6'd27;
    localparam logic [5:0] OP_LDX = 6'd28, OP_LDY = 6'd29, OP_LSR = 6'd30, OP_NOP = 6'd31;
    localparam logic [5:0] OP_ORA = 6'd32, OP_PHA = 6'd33, OP_PHP = 6'd34, OP_SBC = 6'd35;
    localparam logic [5:0] OP_SEC = 6'd36, OP_SED = 6'd37, OP_SEI = 6'd38, OP_STA = 6'd39;
    localparam logic [5:0] OP_STX = 6'd40, OP_STY = 6'd41, OP_TAX = 6'd42, OP_TAY = 6'd43;
    localparam logic [5:0] OP_TSX = 6'd44, OP_TXA = 6'd45, OP_TXS = 6'd46, OP_TYA = 6'd47;

    localparam int unsigned FlagC = 0;
    localparam int unsigned FlagZ = 1;
    localparam int unsigned FlagI = 2;
    localparam int unsigned FlagD = 3;
    localparam int unsigned FlagB = 4;
    localparam int unsigned FlagU = 5;
    localparam int unsigned FlagV = 6;
    localparam int unsigned FlagN = 7;

    localparam logic [7:0]  FlagReset  = 8'h20;
    localparam logic [7:0]  StackReset = 8'hFD;
    localparam logic [7:0]  StackPage  = 8'h01;

    // instruction class set by the front end
    typedef enum logic [3:0] {
        CL_NONE, CL_ALU, CL_RMW, CL_BRANCH, CL_FLAG, CL_CMP, CL_REG,
        CL_JMP, CL_PUSH, CL_STORE, CL_BIT
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [5:0] kind;
        logic [7:0] operand;
        logic [15:0] address;
    } t_dec;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [7:0]  accumulator;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_pointer;
        logic [7:0]  flags;
        logic [15:0] program_counter;
    } t_res;

endpackage

/* hdl/cpu8x_front.sv */
// front end: accepts a word, classifies the operation and queues it
// depends on cpu8x_pkg
module cpu8x_front import cpu8x_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_kind,
    input  logic [7:0]  i_operand,
    input  logic [15:0] i_operand_address,
    output logic        o_dec_valid,
    input  logic        i_dec_ready,
    output t_dec        o_dec
);

    t_dec                 r_q [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QueuePtrW:0]   r_cnt, n_cnt;
    t_class               w_cls;
    logic                 w_push, w_pop;

    always_comb begin
        unique case (i_kind)
            OP_ADC, OP_AND, OP_EOR, OP_ORA, OP_SBC, OP_LDA, OP_LDX, OP_LDY: w_cls = CL_ALU;
            OP_ASL, OP_LSR, OP_INC, OP_DEC: w_cls = CL_RMW;
            OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS: w_cls = CL_BRANCH;
            OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI: w_cls = CL_FLAG;
            OP_CMP, OP_CPX, OP_CPY: w_cls = CL_CMP;
            OP_DEX, OP_DEY, OP_INX, OP_INY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS,
            OP_TYA: w_cls = CL_REG;
            OP_JMP: w_cls = CL_JMP;
            OP_PHA, OP_PHP: w_cls = CL_PUSH;
            OP_STA, OP_STX, OP_STY: w_cls = CL_STORE;
            OP_BIT: w_cls = CL_BIT;
            default: w_cls = CL_NONE;
        endcase
    end

    assign o_ready     = (r_cnt != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth)) ;
    assign o_dec_valid = (r_cnt != '0);
    assign o_dec       = r_q[r_rd];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_dec_valid && i_dec_ready;
    assign n_wr        = w_push ? r_wr + 1'b1 : r_wr;
    assign n_rd        = w_pop ? r_rd + 1'b1 : r_rd;
    assign n_cnt       = r_cnt + (QueuePtrW+1)'(w_push) - (QueuePtrW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wr] <= '{cls: w_cls, kind: i_kind, operand: i_operand,
                           address: i_operand_address};
        end
    end

endmodule

/* hdl/cpu8x_back.sv */
// back end: executes queued words, holds the register file and the result register
// depends on cpu8x_pkg
module cpu8x_back import cpu8x_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_dec_valid,
    output logic o_dec_ready,
    input  t_dec i_dec,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic [7:0]  r_a, r_x, r_y, r_s, r_p;
    logic [15:0] r_pc;
    logic        r_valid;
    t_res        r_res;
    t_res        n_res;
    logic [7:0]  w_m, w_r, w_addm, w_nz;
    logic [8:0]  w_sum, w_diff;
    logic        w_take, w_setnz, w_fire;
    logic [7:0]  w_p;

    assign o_dec_ready = !r_valid || i_ready;
    assign w_fire      = i_dec_valid && o_dec_ready;
    assign w_m         = i_dec.operand;
    assign w_addm      = (i_dec.kind == OP_SBC) ? ~w_m : w_m;
    assign w_sum       = {1'b0, r_a} + {1'b0, w_addm} + {8'd0, r_p[FlagC]};

    always_comb begin
        n_res = '{write_enable: 1'b0, write_address: 16'd0, write_data: 8'd0,
                  accumulator: r_a, index_x: r_x, index_y: r_y, stack_pointer: r_s,
                  flags: r_p, program_counter: r_pc};
        w_p     = r_p;
        w_nz    = 8'd0;
        w_setnz = 1'b0;
        w_r     = 8'd0;
        w_take  = 1'b0;
        w_diff  = 9'd0;
        unique case (i_dec.kind)
            OP_ADC, OP_SBC: begin
                n_res.accumulator = w_sum[7:0];
                w_p[FlagC] = w_sum[8];
                w_p[FlagV] = ~(r_a[7] ^ w_addm[7]) & (r_a[7] ^ w_sum[7]);
                w_nz = w_sum[7:0]; w_setnz = 1'b1;
            end
            OP_AND: begin n_res.accumulator = r_a & w_m; w_nz = r_a & w_m; w_setnz = 1'b1; end
            OP_EOR: begin n_res.accumulator = r_a ^ w_m; w_nz = r_a ^ w_m; w_setnz = 1'b1; end
            OP_ORA: begin n_res.accumulator = r_a | w_m; w_nz = r_a | w_m; w_setnz = 1'b1; end
            OP_LDA: begin n_res.accumulator = w_m; w_nz = w_m; w_setnz = 1'b1; end
            OP_LDX: begin n_res.index_x = w_m; w_nz = w_m; w_setnz = 1'b1; end
            OP_LDY: begin n_res.index_y = w_m; w_nz = w_m; w_setnz = 1'b1; end
            OP_ASL, OP_LSR, OP_INC, OP_DEC: begin
                if (i_dec.kind == OP_ASL) begin
                    w_p[FlagC] = w_m[7]; w_r = {w_m[6:0], 1'b0};
                end else if (i_dec.kind == OP_LSR) begin
                    w_p[FlagC] = w_m[0]; w_r = {1'b0, w_m[7:1]};
                end else if (i_dec.kind == OP_INC) begin
                    w_r = w_m + 8'd1;
                end else begin
                    w_r = w_m - 8'd1;
                end
                w_nz = w_r; w_setnz = 1'b1;
                n_res.write_enable = 1'b1;
                n_res.write_address = i_dec.address;
                n_res.write_data = w_r;
            end
            OP_BCC: w_take = !r_p[FlagC];
            OP_BCS: w_take = r_p[FlagC];
            OP_BEQ: w_take = r_p[FlagZ];
            OP_BNE: w_take = !r_p[FlagZ];
            OP_BMI: w_take = r_p[FlagN];
            OP_BPL: w_take = !r_p[FlagN];
            OP_BVS: w_take = r_p[FlagV];
            OP_BVC: w_take = !r_p[FlagV];
            OP_BIT: begin
                w_p[FlagZ] = ((r_a & w_m) == 8'd0);
                w_p[FlagN] = w_m[7];
                w_p[FlagV] = w_m[6];
            end
            OP_CLC: w_p[FlagC] = 1'b0;
            OP_CLD: w_p[FlagD] = 1'b0;
            OP_CLI: w_p[FlagI] = 1'b0;
            OP_CLV: w_p[FlagV] = 1'b0;
            OP_SEC: w_p[FlagC] = 1'b1;
            OP_SED: w_p[FlagD] = 1'b1;
            OP_SEI: w_p[FlagI] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY: begin
                if (i_dec.kind == OP_CMP) w_diff = {1'b0, r_a} - {1'b0, w_m};
                else if (i_dec.kind == OP_CPX) w_diff = {1'b0, r_x} - {1'b0, w_m};
                else w_diff = {1'b0, r_y} - {1'b0, w_m};
                w_p[FlagC] = !w_diff[8];
                w_nz = w_diff[7:0]; w_setnz = 1'b1;
            end
            OP_DEX: begin n_res.index_x = r_x - 8'd1; w_nz = r_x - 8'd1; w_setnz = 1'b1; end
            OP_DEY: begin n_res.index_y = r_y - 8'd1; w_nz = r_y - 8'd1; w_setnz = 1'b1; end
            OP_INX: begin n_res.index_x = r_x + 8'd1; w_nz = r_x + 8'd1; w_setnz = 1'b1; end
            OP_INY: begin n_res.index_y = r_y + 8'd1; w_nz = r_y + 8'd1; w_setnz = 1'b1; end
            OP_TAX: begin n_res.index_x = r_a; w_nz = r_a; w_setnz = 1'b1; end
            OP_TAY: begin n_res.index_y = r_a; w_nz = r_a; w_setnz = 1'b1; end
            OP_TSX: begin n_res.index_x = r_s; w_nz = r_s; w_setnz = 1'b1; end
            OP_TXA: begin n_res.accumulator = r_x; w_nz = r_x; w_setnz = 1'b1; end
            OP_TYA: begin n_res.accumulator = r_y; w_nz = r_y; w_setnz = 1'b1; end
            OP_TXS: n_res.stack_pointer = r_x;
            OP_JMP: n_res.program_counter = i_dec.address;
            OP_PHA, OP_PHP: begin
                n_res.write_enable = 1'b1;
                n_res.write_address = {StackPage, r_s};
                n_res.write_data = (i_dec.kind == OP_PHA) ? r_a : (r_p | 8'h30);
                n_res.stack_pointer = r_s - 8'd1;
            end
            OP_STA, OP_STX, OP_STY: begin
                n_res.write_enable = 1'b1;
                n_res.write_address = i_dec.address;
                n_res.write_data = (i_dec.kind == OP_STA) ? r_a :
                                   (i_dec.kind == OP_STX) ? r_x : r_y;
            end
            default: ;
        endcase
        if (w_take) begin
            n_res.program_counter = r_pc + {{8{w_m[7]}}, w_m};
        end
        if (w_setnz) begin
            w_p[FlagZ] = (w_nz == 8'd0);
            w_p[FlagN] = w_nz[7];
        end
        w_p[FlagU] = 1'b1;
        w_p[FlagB] = 1'b0;
        n_res.flags = w_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= 8'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_s     <= StackReset;
            r_p     <= FlagReset;
            r_pc    <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_a  <= n_res.accumulator;
                r_x  <= n_res.index_x;
                r_y  <= n_res.index_y;
                r_s  <= n_res.stack_pointer;
                r_p  <= n_res.flags;
                r_pc <= n_res.program_counter;
            end
            if (o_dec_ready) r_valid <= i_dec_valid;
        end
        if (w_fire) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hdl/eight_bit_cpu_execute_unit.sv */
// top level of the 8-bit cpu execute unit: front end, word queue, back end
// depends on cpu8x_pkg, cpu8x_front, cpu8x_back
//
// usage
//   input channel: i_valid / o_ready with i_kind, i_operand, i_operand_address,
//   one decoded instruction per word
//   output channel: o_valid / i_ready with the memory write and the register
//   state after the instruction, one word per instruction, in order
// path: an accepted input word is held in the queue, then in the execute register of
//   the back end, before output valid
// throughput: 1 word per cycle while the receiver does not stall; the register file
//   feeds back into the next instruction through the execute logic
// reset: A, X, Y and PC clear, SP is 0xFD, flags are 0x20, queue and output
//   register empty
// receiver stall: the result is held; the back end stops, the two-entry
//   queue fills, then o_ready falls
module eight_bit_cpu_execute_unit import cpu8x_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_kind,
    input  logic [7:0]  i_operand,
    input  logic [15:0] i_operand_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_write_enable,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic [7:0]  o_accumulator,
    output logic [7:0]  o_index_x,
    output logic [7:0]  o_index_y,
    output logic [7:0]  o_stack_pointer,
    output logic [7:0]  o_flags,
    output logic [15:0] o_program_counter
);

    logic w_dec_valid, w_dec_ready;
    t_dec w_dec;
    t_res w_res;

    cpu8x_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_operand, .i_operand_address,
        .o_dec_valid(w_dec_valid), .i_dec_ready(w_dec_ready), .o_dec(w_dec)
    );

    cpu8x_back u_back (
        .i_clk, .i_rst_n, .i_dec_valid(w_dec_valid), .o_dec_ready(w_dec_ready),
        .i_dec(w_dec), .o_valid, .i_ready, .o_res(w_res)
    );

    assign o_write_enable    = w_res.write_enable;
    assign o_write_address   = w_res.write_address;
    assign o_write_data      = w_res.write_data;
    assign o_accumulator     = w_res.accumulator;
    assign o_index_x         = w_res.index_x;
    assign o_index_y         = w_res.index_y;
    assign o_stack_pointer   = w_res.stack_pointer;
    assign o_flags           = w_res.flags;
    assign o_program_counter = w_res.program_counter;

endmodule
